[src/bas_pkg.sv]
`timescale 1ns / 1ps

package bas_pkg;

	localparam int NumW     = 22;
	localparam int DenW     = 12;
	localparam int DivSteps = NumW;
	localparam int CntW     = $clog2(DivSteps);

	localparam logic [11:0] RcFwdAbove  = 12'd1003;
	localparam logic [11:0] RcRevBelow  = 12'd1000;
	localparam logic [11:0] RcNeutral   = 12'd1002;

	localparam logic [11:0] RstPulseMin  = 12'd1000;
	localparam logic [11:0] RstPulseZero = 12'd1500;
	localparam logic [11:0] RstPulseMax  = 12'd2000;
	localparam logic [7:0]  RstDuty      = 8'd125;
	localparam logic [15:0] RstHold      = 16'd1000;
	localparam logic [6:0]  RstLevel     = 7'd15;

	typedef enum logic [2:0] {
		REG_SOURCE  = 3'd0,
		REG_MIN     = 3'd1,
		REG_ZERO    = 3'd2,
		REG_MAX     = 3'd3,
		REG_DUTY    = 3'd4,
		REG_HOLD    = 3'd5,
		REG_LEVEL   = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		EV_NONE        = 3'd0,
		EV_FWD_RELEASE = 3'd1,
		EV_FWD_BRAKE   = 3'd2,
		EV_REV_RELEASE = 3'd3,
		EV_REV_BRAKE   = 3'd4,
		EV_NEU_BRAKE   = 3'd5,
		EV_HOLD_EXPIRE = 3'd6
	} event_t;

endpackage

[src/bas_if.sv]
`timescale 1ns / 1ps

interface bas_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] throttle;
	logic [31:0]        time_ms;
	modport source (output valid, throttle, time_ms, input ready);
	modport sink   (input valid, throttle, time_ms, output ready);
endinterface

interface bas_out_if;
	logic       valid;
	logic       ready;
	logic       act_dir;
	logic [7:0] pwm_duty;
	logic       brake_active;
	logic       release_active;
	logic [2:0] event_res;
	modport source (output valid, act_dir, pwm_duty, brake_active, release_active,
		event_res, input ready);
	modport sink   (input valid, act_dir, pwm_duty, brake_active, release_active,
		event_res, output ready);
endinterface

interface bas_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[src/bas_div.sv]
`timescale 1ns / 1ps

// restoring divider, one quotient bit per cycle
module bas_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bas_pkg::NumW-1:0]   num,
	input  logic [bas_pkg::DenW-1:0]   den,
	output logic                       done,
	output logic [bas_pkg::NumW-1:0]   quot
);

	logic [bas_pkg::DenW-1:0] rem_q;
	logic [bas_pkg::NumW-1:0] quo_q;
	logic [bas_pkg::CntW-1:0] cnt_q;
	logic                     busy_q;
	logic                     done_q;
	logic [bas_pkg::DenW:0]   trial;
	logic [bas_pkg::DenW:0]   diff;
	logic                     take;

	assign trial = {rem_q, quo_q[bas_pkg::NumW-1]};
	assign diff  = trial - {1'b0, den};
	assign take  = (trial >= {1'b0, den});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == bas_pkg::CntW'(bas_pkg::DivSteps - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= take ? diff[bas_pkg::DenW-1:0] : trial[bas_pkg::DenW-1:0];
			quo_q <= {quo_q[bas_pkg::NumW-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

[src/brake_actuator_sequencer.sv]
`timescale 1ns / 1ps

// Brake actuator sequencer. One command is in flight at a time: cmd.ready is high only
// while the block is idle. A signed command, or an RC neutral or out-of-band width,
// passes PREP, UPD, HOLD and OUT; an RC forward or reverse width adds SCALE, DIV
// and MAP, where the 22-step shared restoring divider maps the pulse width to a
// signed value saturated to 16 bits. OUT waits for a free output register; cmd.ready
// rises in the same cycle as result valid; the next command is taken while a result
// waits. The configuration channel is always ready; write it only while idle.
module brake_actuator_sequencer (
	input  logic            clk,
	input  logic            arst_n,
	bas_cfg_if.sink         cfg,
	bas_in_if.sink          cmd,
	bas_out_if.source       rsp
);

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_PREP  = 8'b0000_0010,
		S_SCALE = 8'b0000_0100,
		S_DIV   = 8'b0000_1000,
		S_MAP   = 8'b0001_0000,
		S_UPD   = 8'b0010_0000,
		S_HOLD  = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	typedef enum logic [1:0] {
		K_NONE = 2'd0,
		K_FWD  = 2'd1,
		K_REV  = 2'd2,
		K_NEU  = 2'd3
	} kind_t;

	state_t state_q;

	// configuration
	logic        src_q;
	logic [11:0] min_q, zero_q, max_q;
	logic [7:0]  duty_q;
	logic [15:0] hold_q;
	logic [6:0]  level_q;

	// sequencer state
	logic signed [15:0] last_q;
	logic               rel_q, brk_q, stop_q, dir_q;
	logic [31:0]        start_q;
	logic [7:0]         hduty_q;

	// per-command working registers
	logic signed [15:0] t_q;
	logic [31:0]        now_q;
	kind_t              kind_q;
	logic signed [16:0] diff_q;
	logic signed [12:0] den_q;
	logic               neg_q, denz_q;
	logic signed [15:0] v_q;
	logic [2:0]         ev_q;

	// output register
	logic       out_valid_q;
	logic       o_dir_q, o_brk_q, o_rel_q;
	logic [7:0] o_duty_q;
	logic [2:0] o_ev_q;

	// divider
	logic                     div_start;
	logic                     div_done;
	logic [bas_pkg::NumW-1:0] div_quot;
	logic [bas_pkg::NumW-1:0] num_mag;
	logic [bas_pkg::DenW-1:0] den_mag;

	logic signed [23:0] d24, num24, num_abs;
	logic signed [12:0] den_abs;
	logic signed [22:0] qs;
	logic signed [23:0] m24;
	logic signed [15:0] m_sat;
	logic signed [16:0] dv;
	logic               rel_ok;
	logic [31:0]        elapsed;
	logic               out_free;

	assign cfg.ready = 1'b1;
	assign cmd.ready = (state_q == S_IDLE);
	assign out_free  = !out_valid_q || rsp.ready;

	assign d24     = {{7{diff_q[16]}}, diff_q};
	assign num24   = (d24 <<< 6) + (d24 <<< 5) + (d24 <<< 2);
	assign num_abs = num24[23] ? -num24 : num24;
	assign den_abs = den_q[12] ? -den_q : den_q;
	assign num_mag = num_abs[bas_pkg::NumW-1:0];
	assign den_mag = den_abs[bas_pkg::DenW-1:0];
	assign div_start = (state_q == S_SCALE);

	bas_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (num_mag),
		.den    (den_mag),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		qs = neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
		if (denz_q)
			qs = '0;
		if (kind_q == K_FWD)
			m24 = {qs[22], qs};
		else
			m24 = 24'sd100 - {qs[22], qs};
		if (m24 > 24'sd32767)
			m_sat = 16'sh7FFF;
		else if (m24 < -24'sd32768)
			m_sat = 16'sh8000;
		else
			m_sat = m24[15:0];
	end

	assign dv      = {v_q[15], v_q} - {last_q[15], last_q};
	assign rel_ok  = (kind_q == K_REV) || !rel_q;
	assign elapsed = now_q - start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q   <= 1'b0;
			min_q   <= bas_pkg::RstPulseMin;
			zero_q  <= bas_pkg::RstPulseZero;
			max_q   <= bas_pkg::RstPulseMax;
			duty_q  <= bas_pkg::RstDuty;
			hold_q  <= bas_pkg::RstHold;
			level_q <= bas_pkg::RstLevel;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				bas_pkg::REG_SOURCE: src_q   <= cfg.data[0];
				bas_pkg::REG_MIN:    min_q   <= cfg.data[11:0];
				bas_pkg::REG_ZERO:   zero_q  <= cfg.data[11:0];
				bas_pkg::REG_MAX:    max_q   <= cfg.data[11:0];
				bas_pkg::REG_DUTY:   duty_q  <= cfg.data[7:0];
				bas_pkg::REG_HOLD:   hold_q  <= cfg.data[15:0];
				bas_pkg::REG_LEVEL:  level_q <= cfg.data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			last_q      <= '0;
			rel_q       <= 1'b0;
			brk_q       <= 1'b0;
			stop_q      <= 1'b0;
			start_q     <= '0;
			dir_q       <= 1'b1;
			hduty_q     <= '0;
			out_valid_q <= 1'b0;
			kind_q      <= K_NONE;
			v_q         <= '0;
			diff_q      <= '0;
			den_q       <= '0;
			neg_q       <= 1'b0;
			denz_q      <= 1'b0;
			ev_q        <= bas_pkg::EV_NONE;
		end else begin
			if (rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid)
						state_q <= S_PREP;
				end
				S_PREP: begin
					state_q <= S_UPD;
					if (!src_q) begin
						if (t_q == 16'sd0)
							kind_q <= K_NEU;
						else if (t_q > 16'sd0) begin
							kind_q <= K_FWD;
							v_q    <= t_q;
						end else begin
							kind_q <= K_REV;
							v_q    <= (t_q == 16'sh8000) ? 16'sh7FFF : -t_q;
						end
					end else if (t_q > $signed({4'b0, bas_pkg::RcFwdAbove})) begin
						kind_q  <= K_FWD;
						diff_q  <= {t_q[15], t_q} - $signed({5'b0, zero_q});
						den_q   <= $signed({1'b0, max_q}) - $signed({1'b0, zero_q});
						state_q <= S_SCALE;
					end else if (t_q < $signed({4'b0, bas_pkg::RcRevBelow})) begin
						kind_q  <= K_REV;
						diff_q  <= {t_q[15], t_q} - $signed({5'b0, min_q});
						den_q   <= $signed({1'b0, zero_q}) - $signed({1'b0, min_q});
						state_q <= S_SCALE;
					end else if (t_q == $signed({4'b0, bas_pkg::RcNeutral}))
						kind_q <= K_NEU;
					else
						kind_q <= K_NONE;
				end
				S_SCALE: begin
					neg_q   <= num24[23] ^ den_q[12];
					denz_q  <= (den_q == 13'sd0);
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done)
						state_q <= S_MAP;
				end
				S_MAP: begin
					v_q     <= m_sat;
					state_q <= S_UPD;
				end
				S_UPD: begin
					ev_q    <= bas_pkg::EV_NONE;
					state_q <= S_HOLD;
					case (kind_q)
						K_FWD, K_REV: begin
							stop_q <= 1'b0;
							if (dv > 17'sd1 && rel_ok) begin
								dir_q   <= 1'b0;
								hduty_q <= duty_q;
								brk_q   <= 1'b0;
								rel_q   <= 1'b1;
								start_q <= now_q;
								last_q  <= v_q;
								ev_q    <= (kind_q == K_REV) ? bas_pkg::EV_REV_RELEASE
									: bas_pkg::EV_FWD_RELEASE;
							end else if (dv < -17'sd1 && v_q < $signed({9'b0, level_q})
								&& !brk_q) begin
								dir_q   <= 1'b1;
								hduty_q <= duty_q;
								brk_q   <= 1'b1;
								rel_q   <= 1'b0;
								start_q <= now_q;
								last_q  <= v_q;
								ev_q    <= (kind_q == K_REV) ? bas_pkg::EV_REV_BRAKE
									: bas_pkg::EV_FWD_BRAKE;
							end
						end
						K_NEU: begin
							if (!brk_q) begin
								if (!stop_q) begin
									dir_q   <= 1'b1;
									hduty_q <= duty_q;
								end
								last_q  <= '0;
								start_q <= now_q;
								brk_q   <= 1'b1;
								ev_q    <= bas_pkg::EV_NEU_BRAKE;
							end
						end
						default: ;
					endcase
				end
				S_HOLD: begin
					if (elapsed > {16'b0, hold_q} && (brk_q || rel_q)) begin
						hduty_q <= '0;
						brk_q   <= 1'b0;
						rel_q   <= 1'b0;
						if (!src_q)
							stop_q <= 1'b1;
						ev_q <= bas_pkg::EV_HOLD_EXPIRE;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			t_q   <= cmd.throttle;
			now_q <= cmd.time_ms;
		end
		if (state_q == S_OUT && out_free) begin
			o_dir_q  <= dir_q;
			o_duty_q <= hduty_q;
			o_brk_q  <= brk_q;
			o_rel_q  <= rel_q;
			o_ev_q   <= ev_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.act_dir        = o_dir_q;
	assign rsp.pwm_duty       = o_duty_q;
	assign rsp.brake_active   = o_brk_q;
	assign rsp.release_active = o_rel_q;
	assign rsp.event_res      = o_ev_q;

endmodule
